// ----- src/idkrt_pkg.sv -----
package idkrt_pkg;

  // Default build sizes
  localparam int TABLE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int ENT_W    = 5;

  localparam logic [ENT_W-1:0] ENT_RESET = 5'd16;
  localparam logic [ID_W-1:0]  ID_MAX    = 16'hFFFF;
  // identifier handed out after the counter wraps; zero is never given
  localparam logic [ID_W-1:0]  ID_T1     = 16'd1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // What the compare unit looks for on the current entry
  typedef struct packed {
    logic            find_free;
    logic [ID_W-1:0] key;
  } scan_req_t;

endpackage

// ----- src/idkrt_if.sv -----
// Command channel
interface idkrt_cmd_if #(
  parameter int DATA_WIDTH = idkrt_pkg::DATA_WIDTH
) ();
  logic                       valid;
  logic                       ready;
  logic [idkrt_pkg::CMD_W-1:0] cmd;
  logic [idkrt_pkg::ID_W-1:0]  record_id;
  logic [DATA_WIDTH-1:0]       record_data;

  modport source (output valid, output cmd, output record_id, output record_data,
                  input ready);
  modport sink   (input valid, input cmd, input record_id, input record_data,
                  output ready);
endinterface

// Result channel
interface idkrt_res_if ();
  logic                          valid;
  logic                          ready;
  logic [idkrt_pkg::STATUS_W-1:0] result_status;
  logic [idkrt_pkg::ID_W-1:0]     given_id;
  logic [idkrt_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, output result_status, output given_id,
                  output slot_index, input ready);
  modport sink   (input valid, input result_status, input given_id,
                  input slot_index, output ready);
endinterface

// ----- src/id_keyed_record_table_top.sv -----
// Record table keyed by identifier.
// request channel (valid/ready): cmd, record_id, record_data. cmd 0 inserts
// record_data into the first free slot and hands out the next identifier
// (1..65535, wrapping to 1); cmd 1 replaces the data of the record with
// record_id; cmd 2 deletes it. cmd 3 changes nothing and reports not found.
// response channel (valid/ready): result_status, given_id, slot_index, one
// transaction per request.
// cfg_we/cfg_data set entries_in_use (reset 16): slots searched from slot 0.
// Timing: one request at a time, the table scanned one slot a cycle through
// the tag RAM's registered read port.
// Reset: the identifier counter at zero; a clearing pass then walks the
// tag RAM, leaving all slots free, and request.ready stays low until it
// finishes.
// A stalled response is held in its output register; the next request is
// still accepted and scanned, then waits until the response slot frees.
module id_keyed_record_table_top #(
  parameter int TABLE_DEPTH = idkrt_pkg::TABLE_DEPTH,
  parameter int DATA_WIDTH  = idkrt_pkg::DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [idkrt_pkg::ENT_W-1:0] cfg_data,
  idkrt_cmd_if.sink                   request,
  idkrt_res_if.source                 response
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  idkrt_pkg::scan_req_t          scan_req;
  logic                          hit;
  logic                          tag_re;
  logic [IDX_W-1:0]              tag_raddr;
  logic                          tag_we;
  logic [IDX_W-1:0]              tag_waddr;
  logic [idkrt_pkg::ID_W:0]      tag_wdata;
  logic [idkrt_pkg::ID_W:0]      tag_rdata;
  logic                          pl_we;
  logic [IDX_W-1:0]              pl_waddr;
  logic [DATA_WIDTH-1:0]         pl_wdata;

  // Sequencer
  idkrt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .in_cmd       (request.cmd),
    .in_id        (request.record_id),
    .in_data      (request.record_data),
    .out_valid    (response.valid),
    .out_ready    (response.ready),
    .out_status   (response.result_status),
    .out_given_id (response.given_id),
    .out_slot     (response.slot_index),
    .scan_req     (scan_req),
    .hit          (hit),
    .tag_re       (tag_re),
    .tag_raddr    (tag_raddr),
    .tag_we       (tag_we),
    .tag_waddr    (tag_waddr),
    .tag_wdata    (tag_wdata),
    .pl_we        (pl_we),
    .pl_waddr     (pl_waddr),
    .pl_wdata     (pl_wdata)
  );

  // Shared compare unit on the entry read last cycle
  idkrt_cmp u_cmp (
    .req         (scan_req),
    .entry_valid (tag_rdata[idkrt_pkg::ID_W]),
    .entry_id    (tag_rdata[idkrt_pkg::ID_W-1:0]),
    .hit         (hit)
  );

  // Valid mark and identifier per slot
  idkrt_ram #(
    .WIDTH (idkrt_pkg::ID_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // Data word per slot
  idkrt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (1'b0),
    .raddr (pl_waddr),
    .rdata ()
  );

endmodule

// ----- src/idkrt_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port
module idkrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/idkrt_cmp.sv -----
// Shared compare unit: tests one table entry per cycle
module idkrt_cmp (
  input  idkrt_pkg::scan_req_t        req,
  input  logic                        entry_valid,
  input  logic [idkrt_pkg::ID_W-1:0]  entry_id,
  output logic                        hit
);

  // free slot for insert, matching live identifier otherwise
  always_comb begin
    if (req.find_free) begin
      hit = !entry_valid;
    end else begin
      hit = entry_valid && (entry_id == req.key);
    end
  end

endmodule

// ----- src/idkrt_seq.sv -----
// Sequencer: clearing pass, slot-by-slot scan, table update and result register
module idkrt_seq #(
  parameter int TABLE_DEPTH = idkrt_pkg::TABLE_DEPTH,
  parameter int DATA_WIDTH  = idkrt_pkg::DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,

  // configuration
  input  logic                         cfg_we,
  input  logic [idkrt_pkg::ENT_W-1:0]  cfg_data,

  // command side
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [idkrt_pkg::CMD_W-1:0]  in_cmd,
  input  logic [idkrt_pkg::ID_W-1:0]   in_id,
  input  logic [DATA_WIDTH-1:0]        in_data,

  // result side
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [idkrt_pkg::STATUS_W-1:0]  out_status,
  output logic [idkrt_pkg::ID_W-1:0]      out_given_id,
  output logic [idkrt_pkg::SLOT_W-1:0]    out_slot,

  // compare unit
  output idkrt_pkg::scan_req_t         scan_req,
  input  logic                         hit,

  // identifier/valid table
  output logic                              tag_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]    tag_raddr,
  output logic                              tag_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]    tag_waddr,
  output logic [idkrt_pkg::ID_W:0]          tag_wdata,

  // payload table
  output logic                              pl_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]    pl_waddr,
  output logic [DATA_WIDTH-1:0]             pl_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LIM_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (LIM_W > idkrt_pkg::ENT_W) ? LIM_W : idkrt_pkg::ENT_W;

  idkrt_pkg::state_t state, state_next;

  logic [idkrt_pkg::ENT_W-1:0]  entries_in_use;
  logic [IDX_W-1:0]             clr_idx;
  logic [idkrt_pkg::CMD_W-1:0]  cmd_q;
  logic [idkrt_pkg::ID_W-1:0]   key_q;
  logic [DATA_WIDTH-1:0]        data_q;
  logic [LIM_W-1:0]             limit_q;
  logic [LIM_W-1:0]             issue_idx;
  logic                         chk_vld;
  logic [IDX_W-1:0]             chk_idx;
  logic                         found;
  logic [IDX_W-1:0]             slot_q;
  logic [idkrt_pkg::ID_W-1:0]   id_ctr;

  logic                         clr_last;
  logic                         cmd_known;
  logic                         issue;
  logic                         hit_now;
  logic                         miss_done;
  logic                         out_free;
  logic                         load;
  logic                         is_insert;
  logic [idkrt_pkg::ID_W-1:0]   new_id;
  logic [LIM_W-1:0]             limit_next;

  // Decode
  assign clr_last  = (clr_idx == IDX_W'(TABLE_DEPTH - 1));
  assign cmd_known = (in_cmd == idkrt_pkg::CMD_INSERT) ||
                     (in_cmd == idkrt_pkg::CMD_MODIFY) ||
                     (in_cmd == idkrt_pkg::CMD_DELETE);
  assign issue     = (issue_idx < limit_q);
  assign hit_now   = chk_vld && hit;
  assign miss_done = !issue && !hit_now;
  assign out_free  = !out_valid || out_ready;
  assign is_insert = (cmd_q == idkrt_pkg::CMD_INSERT);
  assign new_id    = (id_ctr == idkrt_pkg::ID_MAX) ? idkrt_pkg::ID_T1 : id_ctr + 1'b1;

  // Register value above the table depth acts as the full table
  always_comb begin
    if (CMP_W'(entries_in_use) > CMP_W'(TABLE_DEPTH)) begin
      limit_next = LIM_W'(TABLE_DEPTH);
    end else begin
      limit_next = LIM_W'(entries_in_use);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      idkrt_pkg::S_CLEAR: begin
        if (clr_last) state_next = idkrt_pkg::S_IDLE;
      end
      idkrt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = cmd_known ? idkrt_pkg::S_SCAN : idkrt_pkg::S_FINISH;
        end
      end
      idkrt_pkg::S_SCAN: begin
        if (hit_now || miss_done) state_next = idkrt_pkg::S_FINISH;
      end
      idkrt_pkg::S_FINISH: begin
        if (out_free) state_next = idkrt_pkg::S_IDLE;
      end
      default: state_next = idkrt_pkg::S_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = (state == idkrt_pkg::S_IDLE);
    load      = (state == idkrt_pkg::S_FINISH) && out_free;

    scan_req.find_free = is_insert;
    scan_req.key       = key_q;

    tag_re    = (state == idkrt_pkg::S_SCAN) && issue;
    tag_raddr = issue_idx[IDX_W-1:0];

    tag_we    = 1'b0;
    tag_waddr = slot_q;
    tag_wdata = '0;
    pl_we     = 1'b0;
    pl_waddr  = slot_q;
    pl_wdata  = data_q;

    case (state)
      idkrt_pkg::S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx;
      end
      idkrt_pkg::S_FINISH: begin
        if (load && found) begin
          tag_we    = is_insert || (cmd_q == idkrt_pkg::CMD_DELETE);
          tag_wdata = is_insert ? {1'b1, new_id} : '0;
          pl_we     = is_insert || (cmd_q == idkrt_pkg::CMD_MODIFY);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= idkrt_pkg::S_CLEAR;
      entries_in_use <= idkrt_pkg::ENT_RESET;
      clr_idx        <= '0;
      chk_vld        <= 1'b0;
      found          <= 1'b0;
      id_ctr         <= '0;
      out_valid      <= 1'b0;
      issue_idx      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) entries_in_use <= cfg_data;
      if (state == idkrt_pkg::S_CLEAR) clr_idx <= clr_idx + 1'b1;

      case (state)
        idkrt_pkg::S_IDLE: begin
          issue_idx <= '0;
          chk_vld   <= 1'b0;
          found     <= 1'b0;
        end
        idkrt_pkg::S_SCAN: begin
          if (issue) issue_idx <= issue_idx + 1'b1;
          chk_vld <= issue;
          if (hit_now) found <= 1'b1;
        end
        default: begin
        end
      endcase

      if (load && found && is_insert) id_ctr <= new_id;

      // result register
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == idkrt_pkg::S_IDLE) && in_valid) begin
      cmd_q   <= in_cmd;
      key_q   <= in_id;
      data_q  <= in_data;
      limit_q <= limit_next;
    end
    if (state == idkrt_pkg::S_SCAN) begin
      chk_idx <= issue_idx[IDX_W-1:0];
      if (hit_now) slot_q <= chk_idx;
    end
    if (load) begin
      if (found) begin
        out_status   <= idkrt_pkg::STAT_DONE;
        out_given_id <= is_insert ? new_id : '0;
        out_slot     <= idkrt_pkg::SLOT_W'(slot_q);
      end else begin
        out_status   <= is_insert ? idkrt_pkg::STAT_FULL : idkrt_pkg::STAT_NOT_FOUND;
        out_given_id <= '0;
        out_slot     <= '0;
      end
    end
  end

endmodule

// ----- tb/id_keyed_record_table_top_test.sv -----
`timescale 1ns / 1ps

module id_keyed_record_table_top_test;
  import idkrt_pkg::*;

  // Spare command code, not defined by the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Cycles allowed for stray responses once everything has come back
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     given;
    logic [SLOT_W-1:0]   slot;
  } outcome_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [ENT_W-1:0] cfg_data;

  idkrt_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) request_ch ();
  idkrt_res_if response_ch ();

  id_keyed_record_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .request (request_ch),
    .response(response_ch)
  );

  // Shadow of the table: marks, identifiers, counter and register
  logic             tbl_used [TABLE_DEPTH];
  logic [ID_W-1:0]  tbl_key  [TABLE_DEPTH];
  logic [ID_W-1:0]  id_counter_m;
  logic [ENT_W-1:0] entries_m;

  outcome_t awaited_outcomes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int n_sent         = 0;
  int n_done         = 0;
  int n_full         = 0;
  int n_missing      = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Applies one command to the shadow table and returns its outcome
  function automatic outcome_t apply_command(input logic [CMD_W-1:0] op,
                                             input logic [ID_W-1:0]  key);
    outcome_t res;
    int       span;
    int       hit;
    res.status = STAT_NOT_FOUND;
    res.given  = '0;
    res.slot   = '0;
    span = (entries_m > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_m);
    hit  = -1;
    if (op == CMD_INSERT) begin
      // lowest free slot within the searched span
      for (int i = span - 1; i >= 0; i--)
        if (!tbl_used[i]) hit = i;
      if (hit < 0) begin
        res.status = STAT_FULL;
      end else begin
        id_counter_m  = (id_counter_m == ID_MAX) ? 16'd1 : id_counter_m + 16'd1;
        tbl_used[hit] = 1'b1;
        tbl_key[hit]  = id_counter_m;
        res.status    = STAT_DONE;
        res.given     = id_counter_m;
        res.slot      = hit[SLOT_W-1:0];
      end
    end else if (op == CMD_MODIFY || op == CMD_DELETE) begin
      // lowest valid slot carrying the identifier
      for (int i = span - 1; i >= 0; i--)
        if (tbl_used[i] && tbl_key[i] == key) hit = i;
      if (hit >= 0) begin
        if (op == CMD_DELETE) tbl_used[hit] = 1'b0;
        res.status = STAT_DONE;
        res.slot   = hit[SLOT_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  // Sends one command; valid stays high afterwards so back-to-back items need no gap
  task automatic send_cmd(input logic [CMD_W-1:0]      op,
                          input logic [ID_W-1:0]       key,
                          input logic [DATA_WIDTH-1:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    request_ch.valid       <= 1'b1;
    request_ch.cmd         <= op;
    request_ch.record_id   <= key;
    request_ch.record_data <= word;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    awaited_outcomes.push_back(apply_command(op, key));
    n_sent++;
  endtask

  // Holds the request side off until every response is back
  task automatic drain_results();
    request_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0 || request_ch.ready !== 1'b1);
  endtask

  task automatic set_entries(input logic [ENT_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    entries_m  = value;
  endtask

  // Response checker and receiver stalls
  initial begin
    outcome_t want;
    response_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && response_ch.valid === 1'b1 && response_ch.ready === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected response: status %0d id %0d slot %0d",
                                    response_ch.result_status, response_ch.given_id,
                                    response_ch.slot_index));
        end else begin
          want = awaited_outcomes.pop_front();
          if (response_ch.result_status !== want.status)
            report_mismatch($sformatf("result_status %0d, wanted %0d",
                                      response_ch.result_status, want.status));
          if (response_ch.given_id !== want.given)
            report_mismatch($sformatf("given_id %0d, wanted %0d",
                                      response_ch.given_id, want.given));
          if (response_ch.slot_index !== want.slot)
            report_mismatch($sformatf("slot_index %0d, wanted %0d",
                                      response_ch.slot_index, want.slot));
          case (want.status)
            STAT_DONE: n_done++;
            STAT_FULL: n_full++;
            default:   n_missing++;
          endcase
        end
      end
      response_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Basic operations with the register at its reset value
  task automatic test_directed_ops();
    send_cmd(CMD_MODIFY, 16'd0, 32'h1234_5678);       // empty table, identifier zero
    send_cmd(CMD_INSERT, 16'd0, 32'h0000_0000);
    send_cmd(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 16'h5555, 32'hA5A5_A5A5);
    send_cmd(CMD_MODIFY, 16'd2, 32'h5A5A_5A5A);
    send_cmd(CMD_MODIFY, 16'd0, 32'hFFFF_FFFF);       // zero never matches
    send_cmd(CMD_DELETE, 16'd1, 32'd0);
    send_cmd(CMD_DELETE, 16'd1, 32'd0);               // already gone
    send_cmd(CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 16'd2, 32'hFFFF_FFFF);       // spare code changes nothing
    send_cmd(CMD_INSERT, 16'hAAAA, 32'h8000_0001);    // reuses freed slot 0
  endtask

  // Register at zero, above the table, at one and back at the table depth
  task automatic test_register_extremes();
    set_entries(5'd0);
    send_cmd(CMD_INSERT, 16'd0, 32'hDEAD_BEEF);       // full, counter must hold
    send_cmd(CMD_MODIFY, 16'd2, 32'd7);
    send_cmd(CMD_DELETE, 16'd2, 32'd7);
    set_entries(5'd31);
    send_cmd(CMD_INSERT, 16'd0, 32'h0F0F_0F0F);
    set_entries(5'd1);
    send_cmd(CMD_INSERT, 16'd0, 32'h1111_1111);       // slot 0 taken
    send_cmd(CMD_MODIFY, 16'd2, 32'h2222_2222);       // lives outside the span
    send_cmd(CMD_DELETE, 16'd4, 32'd0);
    send_cmd(CMD_INSERT, 16'd0, 32'h3333_3333);
    set_entries(5'd16);
    send_cmd(CMD_MODIFY, 16'd2, 32'h4444_4444);
  endtask

  // Mostly well-formed traffic against live identifiers, in fill and drain bursts
  task automatic random_phase(input int count, input logic [ENT_W-1:0] ent);
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  key;
    int               roll;
    int               pick;
    bit               filling;
    set_entries(ent);
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 39) filling = !filling;
      if (n % 150 == 149) drain_results();
      roll = $urandom_range(99);
      pick = $urandom_range(TABLE_DEPTH - 1);
      key  = tbl_used[pick] ? tbl_key[pick] : ID_W'($urandom());
      if (roll < (filling ? 65 : 25)) begin
        op = CMD_INSERT;
      end else if (roll < 80) begin
        op = $urandom_range(1) ? CMD_MODIFY : CMD_DELETE;
      end else if (roll < 95) begin
        // identifiers that are mostly absent
        op  = $urandom_range(1) ? CMD_MODIFY : CMD_DELETE;
        key = ($urandom_range(3) == 0) ? 16'd0 :
              ($urandom_range(3) == 0) ? ID_MAX : ID_W'($urandom());
      end else begin
        op = CMD_UNUSED;
      end
      send_cmd(op, ($urandom_range(7) == 0) ? ID_W'($urandom()) : key, $urandom());
    end
  endtask

  task automatic test_random_traffic();
    // sender idles lightly, receiver stalls heavily
    send_idle_pct  = 20;
    recv_stall_pct = 72;
    random_phase(260, 5'd16);
    random_phase(80, 5'd1);
    random_phase(180, 5'd7);
    // the other way round
    send_idle_pct  = 72;
    recv_stall_pct = 20;
    random_phase(200, 5'd31);
    random_phase(30, 5'd0);
    random_phase(100, 5'd2);
    random_phase(190, 5'd12);
    // full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(300, 5'd16);
    random_phase(120, 5'd5);
    random_phase(90, 5'd17);
  endtask

  // Sequence of tests
  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_data               <= '0;
    request_ch.valid       <= 1'b0;
    request_ch.cmd         <= CMD_INSERT;
    request_ch.record_id   <= '0;
    request_ch.record_data <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
    end
    id_counter_m = '0;
    entries_m    = ENT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_register_extremes();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands over register values 0 to 31, swapped and absent stalls,",
             n_sent);
    $display("with fill and drain bursts: %0d done, %0d table full, %0d not found.",
             n_done, n_full, n_missing);
    if (errors == 0 && awaited_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
